/* design/cts_pkg.sv */
`default_nettype none
package cts_pkg;

   localparam int NUM_SLOTS   = 8;
   localparam int MAX_RESULTS = 8;
   localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int EMIT_W      = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

   localparam logic [3:0] SLOT_NONE = 4'(NUM_SLOTS);

   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_ADD      = 3'd1,
      OP_DELETE   = 3'd2,
      OP_DISPATCH = 3'd3,
      OP_POWER    = 3'd4
   } op_type;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_WALK
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic single;
      logic walk;
   } ctl_cmd_type;

   typedef struct packed {
      logic walk_op;
      logic walk_done;
   } dp_status_type;

endpackage
`default_nettype wire

/* design/cts_ctrl.sv */
`default_nettype none
module cts_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  cts_pkg::dp_status_type status,
   output cts_pkg::ctl_cmd_type  cmd,
   output logic                  busy
);
   import cts_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.walk_op) begin
               cmd.walk = 1'b1;
               state_in = status.walk_done ? ST_IDLE : ST_WALK;
            end else begin
               cmd.single = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

/* design/cts_datapath.sv */
`default_nettype none
module cts_datapath (
   input  wire                    clock,
   input  wire                    reset,
   input  cts_pkg::ctl_cmd_type   cmd,
   output cts_pkg::dp_status_type status,
   input  wire  [2:0]             req_op,
   input  wire  [2:0]             req_slot_index,
   input  wire  [7:0]             req_task_tag,
   input  wire  [15:0]            req_first_delay,
   input  wire  [15:0]            req_repeat_period,
   input  wire                    csr_wr,
   input  wire  [15:0]            csr_data,
   output logic                   rsp_strobe,
   output logic [3:0]             rsp_slot,
   output logic [7:0]             rsp_ready_tag,
   output logic                   rsp_ready_valid,
   output logic [1:0]             rsp_status,
   output logic                   rsp_running_now,
   output logic                   rsp_last
);
   import cts_pkg::*;

   // slot table
   logic             valid_ff  [NUM_SLOTS];
   logic [7:0]       tag_ff    [NUM_SLOTS];
   logic [15:0]      delay_ff  [NUM_SLOTS];
   logic [15:0]      period_ff [NUM_SLOTS];
   logic [7:0]       count_ff  [NUM_SLOTS];
   logic             valid_in  [NUM_SLOTS];
   logic [7:0]       tag_in    [NUM_SLOTS];
   logic [15:0]      delay_in  [NUM_SLOTS];
   logic [15:0]      period_in [NUM_SLOTS];
   logic [7:0]       count_in  [NUM_SLOTS];

   logic             running_ff, running_in;
   logic [15:0]      tick_step_ff, tick_step_in;
   logic [IDX_W-1:0] ctr_ff, ctr_in;
   logic [EMIT_W-1:0] emit_ff, emit_in;

   // latched item
   logic [2:0]       op_ff, op_in;
   logic [2:0]       idx_ff, idx_in;
   logic [7:0]       atag_ff, atag_in;
   logic [15:0]      adelay_ff, adelay_in;
   logic [15:0]      aperiod_ff, aperiod_in;

   logic             strobe_ff, strobe_in;
   logic [3:0]       slot_ff, slot_in;
   logic [7:0]       rtag_ff, rtag_in;
   logic             rvalid_ff, rvalid_in;
   logic [1:0]       stat_ff, stat_in;
   logic             run_now_ff, run_now_in;
   logic             last_ff, last_in;

   logic [NUM_SLOTS-1:0] pend;
   logic                 pend_any;
   logic                 above_any;
   logic                 free_found;
   logic [IDX_W-1:0]     free_idx;
   logic [IDX_W-1:0]     del_idx;
   logic                 del_in_range;
   logic                 ctr_at_end;
   logic                 walk_done;

   always_comb begin
      pend       = '0;
      above_any  = 1'b0;
      free_found = 1'b0;
      free_idx   = '0;
      for (int j = 0; j < NUM_SLOTS; j++) begin
         pend[j] = (count_ff[j] != 8'd0);
         if (pend[j] && (IDX_W'(j) > ctr_ff)) begin
            above_any = 1'b1;
         end
      end
      // lowest free slot wins
      for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
         if (!valid_ff[j]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(j);
         end
      end
   end

   assign pend_any     = |pend;
   assign del_idx      = IDX_W'(idx_ff);
   assign del_in_range = (32'(idx_ff) < NUM_SLOTS);
   assign ctr_at_end   = (ctr_ff == IDX_W'(NUM_SLOTS - 1));

   always_comb begin
      case (op_ff)
         OP_TICK, OP_POWER: walk_done = ctr_at_end;
         OP_DISPATCH: walk_done = pend[ctr_ff] &&
                                  (!above_any || emit_ff == EMIT_W'(MAX_RESULTS - 1));
         default: walk_done = 1'b1;
      endcase
   end

   assign status.walk_op = ((op_ff == OP_TICK) && running_ff) ||
                           ((op_ff == OP_DISPATCH) && pend_any) ||
                           ((op_ff == OP_POWER) && running_ff);
   assign status.walk_done = walk_done;

   always_comb begin
      for (int j = 0; j < NUM_SLOTS; j++) begin
         valid_in[j]  = valid_ff[j];
         tag_in[j]    = tag_ff[j];
         delay_in[j]  = delay_ff[j];
         period_in[j] = period_ff[j];
         count_in[j]  = count_ff[j];
      end
      running_in   = running_ff;
      tick_step_in = csr_wr ? csr_data : tick_step_ff;
      ctr_in       = ctr_ff;
      emit_in      = emit_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      atag_in      = atag_ff;
      adelay_in    = adelay_ff;
      aperiod_in   = aperiod_ff;
      strobe_in    = 1'b0;
      slot_in      = SLOT_NONE;
      rtag_in      = 8'd0;
      rvalid_in    = 1'b0;
      stat_in      = STATUS_OK;
      last_in      = 1'b1;

      if (cmd.load) begin
         op_in      = req_op;
         idx_in     = req_slot_index;
         atag_in    = req_task_tag;
         adelay_in  = req_first_delay;
         aperiod_in = req_repeat_period;
         ctr_in     = '0;
         emit_in    = '0;
      end

      if (cmd.single) begin
         strobe_in = 1'b1;
         case (op_ff)
            OP_ADD: begin
               if (!free_found) begin
                  stat_in = STATUS_FULL;
               end else begin
                  valid_in[free_idx]  = 1'b1;
                  tag_in[free_idx]    = atag_ff;
                  delay_in[free_idx]  = adelay_ff;
                  period_in[free_idx] = aperiod_ff;
                  count_in[free_idx]  = 8'd0;
                  slot_in             = 4'(free_idx);
               end
            end
            OP_DELETE: begin
               slot_in = 4'(idx_ff);
               stat_in = STATUS_EMPTY;
               if (del_in_range) begin
                  if (valid_ff[del_idx]) begin
                     stat_in = STATUS_OK;
                  end
                  valid_in[del_idx]  = 1'b0;
                  tag_in[del_idx]    = 8'd0;
                  delay_in[del_idx]  = 16'd0;
                  period_in[del_idx] = 16'd0;
                  count_in[del_idx]  = 8'd0;
               end
            end
            OP_POWER: begin
               running_in = ~running_ff;
            end
            default: begin
            end
         endcase
      end

      if (cmd.walk) begin
         ctr_in  = ctr_ff + 1'b1;
         last_in = walk_done;
         case (op_ff)
            OP_TICK: begin
               strobe_in = walk_done;
               if (valid_ff[ctr_ff]) begin
                  if (delay_ff[ctr_ff] == 16'd0) begin
                     if (count_ff[ctr_ff] != 8'hFF) begin
                        count_in[ctr_ff] = count_ff[ctr_ff] + 8'd1;
                     end
                     if (period_ff[ctr_ff] != 16'd0) begin
                        delay_in[ctr_ff] = period_ff[ctr_ff];
                     end
                  end else if (delay_ff[ctr_ff] > tick_step_ff) begin
                     delay_in[ctr_ff] = delay_ff[ctr_ff] - tick_step_ff;
                  end else begin
                     delay_in[ctr_ff] = 16'd0;
                  end
               end
            end
            OP_POWER: begin
               strobe_in        = walk_done;
               delay_in[ctr_ff] = period_ff[ctr_ff];
               if (walk_done) begin
                  running_in = 1'b0;
               end
            end
            OP_DISPATCH: begin
               if (pend[ctr_ff]) begin
                  strobe_in        = 1'b1;
                  slot_in          = 4'(ctr_ff);
                  rtag_in          = tag_ff[ctr_ff];
                  rvalid_in        = 1'b1;
                  emit_in          = emit_ff + 1'b1;
                  count_in[ctr_ff] = count_ff[ctr_ff] - 8'd1;
                  // one-shot task: free the slot
                  if (period_ff[ctr_ff] == 16'd0) begin
                     valid_in[ctr_ff]  = 1'b0;
                     tag_in[ctr_ff]    = 8'd0;
                     delay_in[ctr_ff]  = 16'd0;
                     period_in[ctr_ff] = 16'd0;
                     count_in[ctr_ff]  = 8'd0;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      run_now_in = running_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NUM_SLOTS; j++) begin
            valid_ff[j]  <= 1'b0;
            tag_ff[j]    <= 8'd0;
            delay_ff[j]  <= 16'd0;
            period_ff[j] <= 16'd0;
            count_ff[j]  <= 8'd0;
         end
         running_ff   <= 1'b0;
         tick_step_ff <= 16'd1;
         ctr_ff       <= '0;
         emit_ff      <= '0;
         strobe_ff    <= 1'b0;
      end else begin
         for (int j = 0; j < NUM_SLOTS; j++) begin
            valid_ff[j]  <= valid_in[j];
            tag_ff[j]    <= tag_in[j];
            delay_ff[j]  <= delay_in[j];
            period_ff[j] <= period_in[j];
            count_ff[j]  <= count_in[j];
         end
         running_ff   <= running_in;
         tick_step_ff <= tick_step_in;
         ctr_ff       <= ctr_in;
         emit_ff      <= emit_in;
         strobe_ff    <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      idx_ff     <= idx_in;
      atag_ff    <= atag_in;
      adelay_ff  <= adelay_in;
      aperiod_ff <= aperiod_in;
      slot_ff    <= slot_in;
      rtag_ff    <= rtag_in;
      rvalid_ff  <= rvalid_in;
      stat_ff    <= stat_in;
      run_now_ff <= run_now_in;
      last_ff    <= last_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_slot        = slot_ff;
   assign rsp_ready_tag   = rtag_ff;
   assign rsp_ready_valid = rvalid_ff;
   assign rsp_status      = stat_ff;
   assign rsp_running_now = run_now_ff;
   assign rsp_last        = last_ff;

endmodule
`default_nettype wire

/* design/cooperative_task_scheduler_table.sv */
`default_nettype none
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+---------------------------------
// request   | req_op, req_slot_index, req_task_tag,   | taken when start && !busy
//           | req_first_delay, req_repeat_period      |
// response  | rsp_slot, rsp_ready_tag, rsp_ready_valid| rsp_strobe marks each result
//           | rsp_status, rsp_running_now, rsp_last   |
// csr       | csr_data                                | written when csr_valid && csr_ready
//
// Add, delete, power-on and ticks while stopped give one result from the decode state.
// A tick while running and a power-off walk all NUM_SLOTS slots: the slot walker
// visits one table entry per cycle. A dispatch with a pending slot walks the slots,
// giving a result per pending slot and ending at the last one. busy drops with the final
// result, so the next item may start in the cycle that result is shown. Synchronous reset
// clears the table at once; there is no clearing pass. The response side cannot stall.
module cooperative_task_scheduler_table (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [2:0]  req_op,
   input  wire  [2:0]  req_slot_index,
   input  wire  [7:0]  req_task_tag,
   input  wire  [15:0] req_first_delay,
   input  wire  [15:0] req_repeat_period,
   output logic        rsp_strobe,
   output logic [3:0]  rsp_slot,
   output logic [7:0]  rsp_ready_tag,
   output logic        rsp_ready_valid,
   output logic [1:0]  rsp_status,
   output logic        rsp_running_now,
   output logic        rsp_last,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [15:0] csr_data
);
   import cts_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   cts_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   cts_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_op            (req_op),
      .req_slot_index    (req_slot_index),
      .req_task_tag      (req_task_tag),
      .req_first_delay   (req_first_delay),
      .req_repeat_period (req_repeat_period),
      .csr_wr            (csr_valid && csr_ready),
      .csr_data          (csr_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_slot          (rsp_slot),
      .rsp_ready_tag     (rsp_ready_tag),
      .rsp_ready_valid   (rsp_ready_valid),
      .rsp_status        (rsp_status),
      .rsp_running_now   (rsp_running_now),
      .rsp_last          (rsp_last)
   );

   // an item that is not finished keeps the block busy
   a_mid_item_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> busy)
      else $error("non-final result while idle");

   a_start_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_strobe)
      else $error("item taken without decode cycle");

   a_dispatch_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_ready_valid |-> rsp_status == STATUS_OK && rsp_slot != SLOT_NONE)
      else $error("dispatched result with bad slot or status");

endmodule
`default_nettype wire
